>>> sv/rtt_ping_sampler_assert.svh
// Assertion macros for the rtt ping sampler checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef RTT_PING_SAMPLER_ASSERT_SVH
`define RTT_PING_SAMPLER_ASSERT_SVH

// Property that holds in the same cycle.
`define RTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that holds in the following cycle.
`define RTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rtp_pkg.sv
// Shared types and constants of the rtt ping sampler.
// No dependencies; imported by every module of the block except rtp_ram.
`default_nettype none
package rtp_pkg;

  localparam int unsigned INFLIGHT_LIMIT_DEF = 32;
  localparam int unsigned FLIGHT_SLOTS_DEF   = 64;
  localparam int unsigned WINDOW_DEPTH_DEF   = 64;
  localparam int unsigned TIME_WIDTH_DEF     = 32;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned RTT_W      = 31;
  localparam int unsigned MIN_W      = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned KEEP_W     = 7;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned IN_DW      = 64;
  localparam int unsigned OUT_DW     = 96;
  localparam int unsigned OUT_UW     = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd1000;
  localparam logic [KEEP_W-1:0]     KEEP_RST     = 7'd16;
  localparam logic [RTT_W-1:0]      RTT_MAX      = 31'h7FFF_FFFF;
  localparam logic [SEQ_W-1:0]      SEQ_START    = 32'd1;
  localparam logic [MIN_W-1:0]      MIN_EMPTY    = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_KEEP     = 2'd1;
  localparam logic [1:0] REG_RUN      = 2'd2;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_PONG = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLIGHT,
    ST_RTT,
    ST_WIN,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    FL_IDLE,
    FL_SCAN,
    FL_FIN
  } fl_state_e;

  typedef enum logic {
    WN_IDLE,
    WN_SCAN
  } wn_state_e;

  typedef enum logic {
    OP_PING,
    OP_PONG
  } fl_op_e;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic [KEEP_W-1:0]     keep;
    logic                  run;
  } cfg_t;

  typedef struct packed {
    logic              run_wr;
    logic              run_val;
    logic              keep_wr;
    logic [KEEP_W-1:0] keep_val;
  } cfg_evt_t;

  typedef struct packed {
    logic             start;
    fl_op_e           op;
    logic [SEQ_W-1:0] key;
  } fl_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } fl_sts_t;

  typedef struct packed {
    logic             start;
    logic             push;
    logic [RTT_W-1:0] rtt;
  } win_cmd_t;

  typedef struct packed {
    logic             done;
    logic [MIN_W-1:0] min_rtt;
  } win_sts_t;

endpackage
`default_nettype wire

>>> sv/rtp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module rtp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/rtp_cfg.sv
// APB register file of the rtt ping sampler: interval, keep amount, run.
// Depends on rtp_pkg.
`default_nettype none
module rtp_cfg
  import rtp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o,
  output cfg_evt_t               evt_o
);

  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [KEEP_W-1:0]     keep_q, keep_d;
  logic                  run_q, run_d;
  logic                  wr;
  logic [1:0]            sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = paddr[3:2];

  always_comb begin
    interval_d     = interval_q;
    keep_d         = keep_q;
    run_d          = run_q;
    evt_o.run_wr   = 1'b0;
    evt_o.run_val  = pwdata[0];
    evt_o.keep_wr  = 1'b0;
    evt_o.keep_val = pwdata[KEEP_W-1:0];
    if (wr) begin
      case (sel)
        REG_INTERVAL: interval_d = pwdata[INTERVAL_W-1:0];
        REG_KEEP: begin
          keep_d        = pwdata[KEEP_W-1:0];
          evt_o.keep_wr = 1'b1;
        end
        REG_RUN: begin
          run_d        = pwdata[0];
          evt_o.run_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_INTERVAL: prdata = APB_DW'(interval_q);
      REG_KEEP:     prdata = APB_DW'(keep_q);
      REG_RUN:      prdata = APB_DW'(run_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RST;
      keep_q     <= KEEP_RST;
      run_q      <= 1'b0;
    end else begin
      interval_q <= interval_d;
      keep_q     <= keep_d;
      run_q      <= run_d;
    end
  end

  assign cfg_o.interval = interval_q;
  assign cfg_o.keep     = keep_q;
  assign cfg_o.run      = run_q;

endmodule
`default_nettype wire

>>> sv/rtp_flight.sv
// In-flight ping table: valid flops plus a tag/send-time RAM, scanned one slot a cycle.
// Depends on rtp_pkg and rtp_ram.
`default_nettype none
module rtp_flight
  import rtp_pkg::*;
#(
  parameter int unsigned INFLIGHT_LIMIT = INFLIGHT_LIMIT_DEF,
  parameter int unsigned FLIGHT_SLOTS   = FLIGHT_SLOTS_DEF,
  parameter int unsigned TIME_WIDTH     = TIME_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clr_i,
  input  fl_cmd_t                    cmd_i,
  input  wire logic [TIME_WIDTH-1:0] time_i,
  output fl_sts_t                    sts_o,
  output logic      [TIME_WIDTH-1:0] hit_time_o
);

  localparam int unsigned SA = $clog2(FLIGHT_SLOTS);
  localparam int unsigned CW = $clog2(FLIGHT_SLOTS + 1);
  localparam int unsigned EW = SEQ_W + TIME_WIDTH;

  fl_state_e             state_q, state_d;
  logic [FLIGHT_SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0]         count_q, count_d;
  fl_op_e                op_q, op_d;
  logic [SEQ_W-1:0]      key_q, key_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [SA-1:0]         iss_q, iss_d;
  logic                  iss_on_q, iss_on_d;
  logic                  cmp_on_q, cmp_on_d;
  logic [SA-1:0]         cmp_idx_q, cmp_idx_d;
  logic                  found_q, found_d;
  logic [SA-1:0]         slot_q, slot_d;
  logic                  free_found_q, free_found_d;
  logic [SA-1:0]         free_idx_q, free_idx_d;
  logic [TIME_WIDTH-1:0] hit_time_q, hit_time_d;

  logic                  ram_we;
  logic [SA-1:0]         ram_waddr;
  logic [EW-1:0]         ram_rdata;
  logic                  ram_re;
  logic [SEQ_W-1:0]      rd_tag;
  logic [TIME_WIDTH-1:0] rd_time;

  assign rd_tag  = ram_rdata[EW-1:TIME_WIDTH];
  assign rd_time = ram_rdata[TIME_WIDTH-1:0];
  assign ram_re  = (state_q == FL_SCAN) && iss_on_q;

  rtp_ram #(
    .WIDTH(EW),
    .DEPTH(FLIGHT_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({key_q, time_q}),
    .re_i   (ram_re),
    .raddr_i(iss_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    count_d      = count_q;
    op_d         = op_q;
    key_d        = key_q;
    time_d       = time_q;
    iss_d        = iss_q;
    iss_on_d     = iss_on_q;
    cmp_on_d     = cmp_on_q;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    slot_d       = slot_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    hit_time_d   = hit_time_q;
    ram_we       = 1'b0;
    ram_waddr    = slot_q;
    sts_o.done   = 1'b0;
    sts_o.hit    = found_q;

    case (state_q)
      FL_IDLE: begin
        if (cmd_i.start) begin
          op_d         = cmd_i.op;
          key_d        = cmd_i.key;
          time_d       = time_i;
          iss_d        = '0;
          iss_on_d     = 1'b1;
          cmp_on_d     = 1'b0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          if (cmd_i.op == OP_PING && (32'(count_q) > 32'(INFLIGHT_LIMIT) ||
                                      32'(count_q) >= 32'(FLIGHT_SLOTS))) begin
            valid_d = '0;
            count_d = '0;
          end
          state_d = FL_SCAN;
        end
      end
      FL_SCAN: begin
        if (iss_on_q) begin
          iss_d = iss_q + 1'b1;
          if (iss_q == SA'(FLIGHT_SLOTS - 1)) begin
            iss_on_d = 1'b0;
          end
        end
        cmp_on_d  = iss_on_q;
        cmp_idx_d = iss_q;
        if (cmp_on_q) begin
          if (!valid_q[cmp_idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
          if (valid_q[cmp_idx_q] && rd_tag == key_q) begin
            found_d    = 1'b1;
            slot_d     = cmp_idx_q;
            hit_time_d = rd_time;
            iss_on_d   = 1'b0;
            cmp_on_d   = 1'b0;
            state_d    = FL_FIN;
          end else if (cmp_idx_q == SA'(FLIGHT_SLOTS - 1)) begin
            state_d = FL_FIN;
          end
        end
      end
      FL_FIN: begin
        sts_o.done = 1'b1;
        state_d    = FL_IDLE;
        if (op_q == OP_PING) begin
          if (found_q) begin
            ram_we = 1'b1;
          end else if (free_found_q) begin
            ram_we              = 1'b1;
            ram_waddr           = free_idx_q;
            valid_d[free_idx_q] = 1'b1;
            count_d             = count_q + 1'b1;
          end
        end else if (found_q) begin
          valid_d[slot_q] = 1'b0;
          count_d         = count_q - 1'b1;
        end
      end
      default: state_d = FL_IDLE;
    endcase

    if (clr_i) begin
      valid_d = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FL_IDLE;
      valid_q  <= '0;
      count_q  <= '0;
      iss_on_q <= 1'b0;
      cmp_on_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      count_q  <= count_d;
      iss_on_q <= iss_on_d;
      cmp_on_q <= cmp_on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    time_q       <= time_d;
    iss_q        <= iss_d;
    cmp_idx_q    <= cmp_idx_d;
    found_q      <= found_d;
    slot_q       <= slot_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    hit_time_q   <= hit_time_d;
  end

  assign hit_time_o = hit_time_q;

endmodule
`default_nettype wire

>>> sv/rtp_window.sv
// Sample window: ring of round-trip times in RAM with a serial minimum scan.
// Depends on rtp_pkg and rtp_ram.
`default_nettype none
module rtp_window
  import rtp_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cfg_evt_t               evt_i,
  input  wire logic [KEEP_W-1:0] keep_i,
  input  win_cmd_t               cmd_i,
  output win_sts_t               sts_o
);

  localparam int unsigned WA = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

  function automatic logic [CW-1:0] keep_eff(input logic [KEEP_W-1:0] k);
    logic [CW-1:0] r;
    if (k == '0) begin
      r = CW'(1);
    end else if (32'(k) > 32'(WINDOW_DEPTH)) begin
      r = CW'(WINDOW_DEPTH);
    end else begin
      r = CW'(k);
    end
    return r;
  endfunction

  function automatic logic [WA-1:0] ptr_dec(input logic [WA-1:0] p);
    logic [WA-1:0] r;
    if (p == '0) begin
      r = WA'(WINDOW_DEPTH - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

  wn_state_e        state_q, state_d;
  logic [WA-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [WA-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    left_q, left_d;
  logic             cmp_on_q, cmp_on_d;
  logic [RTT_W-1:0] min_q, min_d;
  logic             done_q, done_d;
  logic [MIN_W-1:0] res_q, res_d;

  logic             ram_we;
  logic             ram_re;
  logic [RTT_W-1:0] ram_rdata;
  logic [CW-1:0]    cnt_inc;
  logic [CW-1:0]    keep_now;
  logic [CW-1:0]    keep_new;

  assign keep_now = keep_eff(keep_i);
  assign keep_new = keep_eff(evt_i.keep_val);
  assign cnt_inc  = (count_q == CW'(WINDOW_DEPTH)) ? count_q : count_q + 1'b1;
  assign ram_we   = (state_q == WN_IDLE) && cmd_i.start && cmd_i.push;
  assign ram_re   = (state_q == WN_SCAN) && (left_q != '0);

  rtp_ram #(
    .WIDTH(RTT_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(cmd_i.rtt),
    .re_i   (ram_re),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    left_d   = left_q;
    cmp_on_d = 1'b0;
    min_d    = min_q;
    done_d   = 1'b0;
    res_d    = res_q;

    case (state_q)
      WN_IDLE: begin
        if (cmd_i.start) begin
          if (cmd_i.push) begin
            head_d  = (head_q == WA'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d = (cnt_inc > keep_now) ? keep_now : cnt_inc;
          end
          ptr_d   = ptr_dec(head_d);
          left_d  = count_d;
          min_d   = RTT_MAX;
          state_d = WN_SCAN;
        end
      end
      WN_SCAN: begin
        if (left_q != '0) begin
          ptr_d    = ptr_dec(ptr_q);
          left_d   = left_q - 1'b1;
          cmp_on_d = 1'b1;
        end
        if (cmp_on_q && ram_rdata < min_q) begin
          min_d = ram_rdata;
        end
        if (left_q == '0 && !cmp_on_q) begin
          done_d  = 1'b1;
          res_d   = (count_q == '0) ? MIN_EMPTY : {1'b0, min_q};
          state_d = WN_IDLE;
        end
      end
      default: state_d = WN_IDLE;
    endcase

    if (evt_i.keep_wr && count_q > keep_new) begin
      count_d = keep_new;
    end
    if (evt_i.run_wr && !evt_i.run_val) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= WN_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      left_q   <= '0;
      cmp_on_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      left_q   <= left_d;
      cmp_on_q <= cmp_on_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    min_q <= min_d;
    res_q <= res_d;
  end

  assign sts_o.done    = done_q;
  assign sts_o.min_rtt = res_q;

endmodule
`default_nettype wire

>>> sv/rtt_ping_sampler.sv
// Round-trip-time probe engine: tick and pong requests in, one result per request out.
// One request is processed at a time. Tick requests issue pings on the configured interval;
// pong requests match the in-flight table and feed the sample window.
// Register port: APB, interval_ms at 0x0, keep_amount at 0x4, run_enable at 0x8.
// Writing run_enable restarts (1) or stops (0) the engine; pready is always high.
// A tick that issues no ping runs only the window minimum scan. A ping or pong
// adds the in-flight table scan before it; a pong hit ends the table scan early.
// The two serial RAM scans set the worst-case time per request.
// Reset: registers 1000, 16 and stopped; table empty, window empty, sequence 1.
// The result waits in the output register while m_axis_tready is low; the next request
// is accepted meanwhile and holds before its result until that register is taken.
// Depends on rtp_pkg, rtp_cfg, rtp_flight, rtp_window.
`default_nettype none
module rtt_ping_sampler
  import rtp_pkg::*;
#(
  parameter int unsigned INFLIGHT_LIMIT = INFLIGHT_LIMIT_DEF,
  parameter int unsigned FLIGHT_SLOTS   = FLIGHT_SLOTS_DEF,
  parameter int unsigned WINDOW_DEPTH   = WINDOW_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH     = TIME_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_DW-1:0]  s_axis_tdata,   // time_ms[31:0], pong_seq[63:32]
  input  wire logic              s_axis_tuser,   // req_type
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_DW-1:0] m_axis_tdata,   // issued_seq[31:0], rtt_ms[62:32],
                                                 // min_rtt_ms[94:63], zero[95]
  output logic      [OUT_UW-1:0] m_axis_tuser    // ping_issued[0], sample_added[1]
);

  cfg_t                  cfg;
  cfg_evt_t              evt;
  fl_cmd_t               fl_cmd;
  fl_sts_t               fl_sts;
  logic [TIME_WIDTH-1:0] fl_hit_time;
  win_cmd_t              win_cmd;
  win_sts_t              win_sts;

  top_state_e            state_q, state_d;
  logic                  type_q, type_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [SEQ_W-1:0]      pseq_q, pseq_d;
  logic [TIME_WIDTH-1:0] diff_q, diff_d;
  logic [SEQ_W-1:0]      next_seq_q, next_seq_d;
  logic [TIME_WIDTH-1:0] last_send_q, last_send_d;
  logic                  sent_q, sent_d;
  logic                  ping_q, ping_d;
  logic [SEQ_W-1:0]      seq_q, seq_d;
  logic                  added_q, added_d;
  logic [RTT_W-1:0]      rtt_q, rtt_d;
  logic                  m_valid_q, m_valid_d;
  logic                  o_ping_q, o_ping_d;
  logic [SEQ_W-1:0]      o_seq_q, o_seq_d;
  logic                  o_added_q, o_added_d;
  logic [RTT_W-1:0]      o_rtt_q, o_rtt_d;
  logic [MIN_W-1:0]      o_min_q, o_min_d;

  logic [TIME_WIDTH-1:0] in_time;
  logic [INTERVAL_W-1:0] iv;
  logic [63:0]           diff_ext;
  logic [RTT_W-1:0]      rtt_clamp;

  assign in_time  = TIME_WIDTH'(s_axis_tdata[31:0]);
  assign iv       = (cfg.interval == '0) ? INTERVAL_W'(1) : cfg.interval;
  assign diff_ext = 64'(diff_q);

  always_comb begin
    if (diff_q[TIME_WIDTH-1]) begin
      rtt_clamp = '0;
    end else if (diff_ext > 64'(RTT_MAX)) begin
      rtt_clamp = RTT_MAX;
    end else begin
      rtt_clamp = RTT_W'(diff_ext);
    end
  end

  rtp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg),
    .evt_o  (evt)
  );

  rtp_flight #(
    .INFLIGHT_LIMIT(INFLIGHT_LIMIT),
    .FLIGHT_SLOTS  (FLIGHT_SLOTS),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_flight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (evt.run_wr),
    .cmd_i     (fl_cmd),
    .time_i    (now_q),
    .sts_o     (fl_sts),
    .hit_time_o(fl_hit_time)
  );

  rtp_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .keep_i(cfg.keep),
    .cmd_i (win_cmd),
    .sts_o (win_sts)
  );

  always_comb begin
    state_d       = state_q;
    type_d        = type_q;
    now_d         = now_q;
    pseq_d        = pseq_q;
    diff_d        = diff_q;
    next_seq_d    = next_seq_q;
    last_send_d   = last_send_q;
    sent_d        = sent_q;
    ping_d        = ping_q;
    seq_d         = seq_q;
    added_d       = added_q;
    rtt_d         = rtt_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    o_ping_d      = o_ping_q;
    o_seq_d       = o_seq_q;
    o_added_d     = o_added_q;
    o_rtt_d       = o_rtt_q;
    o_min_d       = o_min_q;
    s_axis_tready = 1'b0;
    fl_cmd.start  = 1'b0;
    fl_cmd.op     = OP_PING;
    fl_cmd.key    = next_seq_q;
    win_cmd.start = 1'b0;
    win_cmd.push  = 1'b0;
    win_cmd.rtt   = rtt_clamp;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          type_d  = s_axis_tuser;
          now_d   = in_time;
          pseq_d  = s_axis_tdata[63:32];
          diff_d  = in_time - last_send_q;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ping_d  = 1'b0;
        seq_d   = '0;
        added_d = 1'b0;
        rtt_d   = '0;
        if (type_q == REQ_PONG) begin
          fl_cmd.start = 1'b1;
          fl_cmd.op    = OP_PONG;
          fl_cmd.key   = pseq_q;
          state_d      = ST_FLIGHT;
        end else if (cfg.run && (!sent_q || (!diff_q[TIME_WIDTH-1] &&
                                             diff_q >= TIME_WIDTH'(iv)))) begin
          ping_d       = 1'b1;
          seq_d        = next_seq_q;
          next_seq_d   = next_seq_q + 1'b1;
          last_send_d  = now_q;
          sent_d       = 1'b1;
          fl_cmd.start = 1'b1;
          state_d      = ST_FLIGHT;
        end else begin
          win_cmd.start = 1'b1;
          state_d       = ST_WIN;
        end
      end
      ST_FLIGHT: begin
        if (fl_sts.done) begin
          if (type_q == REQ_PONG && fl_sts.hit) begin
            diff_d  = now_q - fl_hit_time;
            state_d = ST_RTT;
          end else begin
            win_cmd.start = 1'b1;
            state_d       = ST_WIN;
          end
        end
      end
      ST_RTT: begin
        added_d       = 1'b1;
        rtt_d         = rtt_clamp;
        win_cmd.start = 1'b1;
        win_cmd.push  = 1'b1;
        state_d       = ST_WIN;
      end
      ST_WIN: begin
        if (win_sts.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          o_ping_d  = ping_q;
          o_seq_d   = seq_q;
          o_added_d = added_q;
          o_rtt_d   = rtt_q;
          o_min_d   = win_sts.min_rtt;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (evt.run_wr) begin
      sent_d = 1'b0;
      if (evt.run_val) begin
        next_seq_d = SEQ_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_seq_q  <= SEQ_START;
      last_send_q <= '0;
      sent_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_seq_q  <= next_seq_d;
      last_send_q <= last_send_d;
      sent_q      <= sent_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    now_q     <= now_d;
    pseq_q    <= pseq_d;
    diff_q    <= diff_d;
    ping_q    <= ping_d;
    seq_q     <= seq_d;
    added_q   <= added_d;
    rtt_q     <= rtt_d;
    o_ping_q  <= o_ping_d;
    o_seq_q   <= o_seq_d;
    o_added_q <= o_added_d;
    o_rtt_q   <= o_rtt_d;
    o_min_q   <= o_min_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, o_min_q, o_rtt_q, o_seq_q};
  assign m_axis_tuser  = {o_added_q, o_ping_q};

endmodule
`default_nettype wire

>>> sv/rtp_checker.sv
// Port-level checker for the rtt ping sampler, bound to the top level.
// Depends on rtp_pkg and rtt_ping_sampler_assert.svh.
`default_nettype none
`include "rtt_ping_sampler_assert.svh"
module rtp_checker
  import rtp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [OUT_DW-1:0] m_axis_tdata,
  input wire logic [OUT_UW-1:0] m_axis_tuser
);

  `RTP_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")
  `RTP_ASSERT_NOW(a_ping_xor_sample, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1], "ping and sample in one result")
  `RTP_ASSERT_NOW(a_sample_sets_min, m_axis_tvalid && m_axis_tuser[1], !m_axis_tdata[94], "empty window after new sample")
  `RTP_ASSERT_NOW(a_idle_seq_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:0] == '0, "sequence without ping")
  `RTP_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind rtt_ping_sampler rtp_checker u_rtp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
